// ===== design/rse_pkg.sv =====
// Shared constants, types and the GF(256) multiply helper for the Reed-Solomon encoder.
package rse_pkg;

  localparam int          MAX_ECC_LENGTH_DEF = 32;
  localparam logic [8:0]  FIELD_POLY         = 9'h11D;
  localparam logic [7:0]  PRIM_ELEM          = 8'h02;
  localparam logic [7:0]  BYTE_MASK          = 8'hFF;
  localparam logic [5:0]  ECC_LEN_RESET      = 6'd10;

  typedef enum logic [1:0] {
    ST_INIT,
    ST_BUILD,
    ST_RUN
  } build_state_t;

  // per-cycle command broadcast to every cell of the chain
  typedef struct packed {
    logic       init;    // load starting generator, clear remainder
    logic       build;   // one generator multiply-by-root step
    logic       step;    // absorb one message byte
    logic       load;    // copy updated remainder into the output chain
    logic       shift;   // move output chain one place towards cell 0
    logic [7:0] mult_b;  // root while building, feedback factor while encoding
  } rse_ctrl_t;

  // GF(256) multiply, MSB-first shift and add
  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] acc;
    acc = '0;
    for (int bit_i = 7; bit_i >= 0; bit_i--) begin
      acc = (acc << 1) ^ (acc[7] ? FIELD_POLY[7:0] : 8'h00);
      acc = acc ^ (b[bit_i] ? a : 8'h00);
    end
    return acc & BYTE_MASK;
  endfunction

endpackage

// ===== design/reed_solomon_ecc_encoder_core.sv =====
// Top level: QR-style Reed-Solomon ECC encoder over GF(256), chain of cells.
// Latency: a message byte is absorbed in the cycle it is accepted; the ECC bytes are valid
//   from the cycle after the last message byte is accepted, n bytes, one a cycle unless out_stall.
// Throughput: one message byte per cycle while in_stall is low, set by the single-step
//   remainder update per cell; the next message streams in while the previous remainder
//   drains through the output chain, its last byte waits until that drain is done.
// Reset / ecc_length write: generator reloaded, then rebuilt with one multiply per cell
//   per cycle, input stalled meanwhile; synchronous active-low reset, ecc_length back to 10.
module reed_solomon_ecc_encoder_core #(
  parameter int MAX_ECC_LENGTH = rse_pkg::MAX_ECC_LENGTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic [5:0] cfg_wr_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_data_byte,
  input  logic       in_last_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_ecc_byte,
  output logic       out_ecc_last
);
  import rse_pkg::*;

  localparam int LW = $clog2(MAX_ECC_LENGTH + 1);
  localparam int CW = (LW > 6) ? LW : 6;

  build_state_t   state_r, state_nxt;
  logic [5:0]     len_r, len_nxt;
  logic [LW-1:0]  iter_r, iter_nxt;
  logic [7:0]     root_r, root_nxt;
  logic [LW-1:0]  cnt_r, cnt_nxt;
  logic [CW-1:0]  len_ext;
  logic [LW-1:0]  ecc_n;
  logic           in_fire;
  logic           out_fire;
  logic           drain_ok;
  logic [7:0]     factor;
  rse_ctrl_t      ctrl;

  logic [7:0] rem_w [MAX_ECC_LENGTH+1];
  logic [7:0] gen_w [MAX_ECC_LENGTH+1];
  logic [7:0] out_w [MAX_ECC_LENGTH+1];

  // zero selects one byte, anything above the chain length selects the full chain
  assign len_ext = CW'(len_r);
  always_comb begin
    if (len_ext == '0) begin
      ecc_n = LW'(1);
    end else if (len_ext > CW'(MAX_ECC_LENGTH)) begin
      ecc_n = LW'(MAX_ECC_LENGTH);
    end else begin
      ecc_n = LW'(len_ext);
    end
  end

  assign out_valid    = cnt_r != '0;
  assign out_ecc_last = cnt_r == LW'(1);
  assign out_ecc_byte = out_w[0];
  assign out_fire     = out_valid && !out_stall;

  // a last byte may only reload the output chain once it is empty or its last byte leaves
  assign drain_ok = (cnt_r == '0) || (out_ecc_last && out_fire);
  assign in_stall = (state_r != ST_RUN) || (in_last_byte && !drain_ok);
  assign in_fire  = in_valid && !in_stall;
  assign factor   = in_data_byte ^ rem_w[0];

  always_comb begin
    ctrl.init   = state_r == ST_INIT;
    ctrl.build  = state_r == ST_BUILD;
    ctrl.step   = in_fire;
    ctrl.load   = in_fire && in_last_byte;
    ctrl.shift  = out_fire;
    ctrl.mult_b = (state_r == ST_BUILD) ? root_r : factor;
  end

  always_comb begin
    state_nxt = state_r;
    iter_nxt  = iter_r;
    root_nxt  = root_r;
    len_nxt   = len_r;
    unique case (state_r)
      ST_INIT: begin
        state_nxt = ST_BUILD;
        iter_nxt  = '0;
        root_nxt  = 8'h01;
      end
      ST_BUILD: begin
        iter_nxt = iter_r + LW'(1);
        root_nxt = gf_mul(root_r, PRIM_ELEM);
        if (iter_r == ecc_n - LW'(1)) begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        state_nxt = ST_RUN;
      end
      default: begin
        state_nxt = ST_INIT;
      end
    endcase
    if (cfg_wr_en) begin
      len_nxt   = cfg_wr_data;
      state_nxt = ST_INIT;
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (ctrl.load) begin
      cnt_nxt = ecc_n;
    end else if (out_fire) begin
      cnt_nxt = cnt_r - LW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_INIT;
      len_r   <= ECC_LEN_RESET;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      len_r   <= len_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    iter_r <= iter_nxt;
    root_r <= root_nxt;
  end

  assign rem_w[MAX_ECC_LENGTH] = 8'h00;
  assign gen_w[MAX_ECC_LENGTH] = 8'h00;
  assign out_w[MAX_ECC_LENGTH] = 8'h00;

  for (genvar j = 0; j < MAX_ECC_LENGTH; j++) begin : g_cell
    rse_cell #(
      .MAX_ECC_LENGTH (MAX_ECC_LENGTH),
      .IDX            (j)
    ) u_cell (
      .clk    (clk),
      .ctrl   (ctrl),
      .ecc_n  (ecc_n),
      .rem_nb (rem_w[j+1]),
      .gen_nb (gen_w[j+1]),
      .out_nb (out_w[j+1]),
      .rem_q  (rem_w[j]),
      .gen_q  (gen_w[j]),
      .out_q  (out_w[j])
    );
  end

endmodule

// ===== design/rse_cell.sv =====
// One cell of the encoder chain: generator coefficient, remainder byte, output byte.
module rse_cell #(
  parameter int MAX_ECC_LENGTH = rse_pkg::MAX_ECC_LENGTH_DEF,
  parameter int IDX            = 0
) (
  input  logic                                  clk,
  input  rse_pkg::rse_ctrl_t                    ctrl,
  input  logic [$clog2(MAX_ECC_LENGTH+1)-1:0]   ecc_n,
  input  logic [7:0]                            rem_nb,
  input  logic [7:0]                            gen_nb,
  input  logic [7:0]                            out_nb,
  output logic [7:0]                            rem_q,
  output logic [7:0]                            gen_q,
  output logic [7:0]                            out_q
);
  import rse_pkg::*;

  localparam int LW = $clog2(MAX_ECC_LENGTH + 1);

  logic [7:0] rem_r, rem_nxt;
  logic [7:0] gen_r, gen_nxt;
  logic [7:0] out_r, out_nxt;
  logic [7:0] prod;
  logic [7:0] rem_step;
  logic       use_nb;
  logic       is_top;

  // neighbour term only counts below the top active coefficient
  assign use_nb   = LW'(IDX + 1) < ecc_n;
  assign is_top   = LW'(IDX + 1) == ecc_n;
  assign prod     = gf_mul(gen_r, ctrl.mult_b);
  assign rem_step = (use_nb ? rem_nb : 8'h00) ^ prod;

  always_comb begin
    rem_nxt = rem_r;
    gen_nxt = gen_r;
    out_nxt = out_r;
    if (ctrl.init) begin
      rem_nxt = 8'h00;
      gen_nxt = is_top ? 8'h01 : 8'h00;
    end else if (ctrl.build) begin
      gen_nxt = prod ^ (use_nb ? gen_nb : 8'h00);
    end else if (ctrl.step) begin
      rem_nxt = ctrl.load ? 8'h00 : rem_step;
    end
    if (ctrl.load) begin
      out_nxt = rem_step;
    end else if (ctrl.shift) begin
      out_nxt = out_nb;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    gen_r <= gen_nxt;
    out_r <= out_nxt;
  end

  assign rem_q = rem_r;
  assign gen_q = gen_r;
  assign out_q = out_r;

endmodule

// ===== design/rse_checker.sv =====
// Port-level assertions for the encoder top level, bound in below.
module rse_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       cfg_wr_en,
  input logic [5:0] cfg_wr_data,
  input logic       in_valid,
  input logic       in_stall,
  input logic [7:0] in_data_byte,
  input logic       in_last_byte,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_ecc_byte,
  input logic       out_ecc_last
);

  // a stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_ecc_byte) && $stable(out_ecc_last))
    else $error("result changed while stalled");

  // generator rebuild blocks input after a length write
  a_cfg_stall: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr_en |=> in_stall)
    else $error("input taken during generator rebuild");

  // reset starts a rebuild, so input must be held off
  a_rst_stall: assert property (@(posedge clk)
    !rst_n |=> in_stall)
    else $error("input taken straight after reset");

  // only a last byte can start a remainder drain
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && !in_last_byte && !out_valid |=> !out_valid)
    else $error("result without a last byte");

endmodule

bind reed_solomon_ecc_encoder_core rse_checker u_rse_checker (.*);

// ===== sim/tb_top.sv =====
// Self-checking testbench for the GF(256) Reed-Solomon ECC encoder core.
`timescale 1ns / 100ps

module tb_top;
  import rse_pkg::*;

  localparam int          MAXN        = MAX_ECC_LENGTH_DEF;
  localparam logic [7:0]  POLY_LOW    = FIELD_POLY[7:0];
  localparam int          CYCLE_LIMIT = 200000;
  localparam int          SETTLE      = MAXN + 8;

  typedef struct packed {
    logic [7:0] ecc_byte;
    logic       ecc_last;
  } ecc_item_t;

  logic       clk          = 1'b0;
  logic       rst_n        = 1'b0;
  logic       cfg_wr_en    = 1'b0;
  logic [5:0] cfg_wr_data  = '0;
  logic       in_valid     = 1'b0;
  logic       in_stall;
  logic [7:0] in_data_byte = '0;
  logic       in_last_byte = 1'b0;
  logic       out_valid;
  logic       out_stall    = 1'b0;
  logic [7:0] out_ecc_byte;
  logic       out_ecc_last;

  // predictor state
  logic [7:0]  gen_coef [MAXN];
  logic [7:0]  rem_reg  [MAXN];
  int unsigned eff_n;
  ecc_item_t   pending_ecc [$];

  int mismatch_count = 0;
  int cycle_count    = 0;
  int send_gap_pct   = 0;
  int out_stall_pct  = 0;

  reed_solomon_ecc_encoder_core u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data_byte (in_data_byte),
    .in_last_byte (in_last_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_ecc_byte (out_ecc_byte),
    .out_ecc_last (out_ecc_last)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // LSB-first multiply, reducing by the field polynomial as a is doubled
  function automatic logic [7:0] gf256_product(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] p;
    p = '0;
    for (int k = 0; k < 8; k++) begin
      if (b[k]) p = p ^ a;
      a = {a[6:0], 1'b0} ^ (a[7] ? POLY_LOW : 8'h00);
    end
    return p;
  endfunction

  function automatic void rebuild_generator(input logic [5:0] len);
    logic [7:0] root;
    logic [7:0] c;
    eff_n = len;
    if (eff_n < 1) eff_n = 1;
    if (eff_n > MAXN) eff_n = MAXN;
    for (int j = 0; j < MAXN; j++) begin
      gen_coef[j] = '0;
      rem_reg[j]  = '0;
    end
    gen_coef[eff_n-1] = 8'h01;
    root = 8'h01;
    for (int i = 0; i < eff_n; i++) begin
      for (int j = 0; j < eff_n; j++) begin
        c = gf256_product(gen_coef[j], root);
        if (j + 1 < eff_n) c = c ^ gen_coef[j+1];
        gen_coef[j] = c;
      end
      root = gf256_product(root, PRIM_ELEM);
    end
  endfunction

  // one division step; on the last byte queue the whole remainder and clear it
  function automatic void absorb_byte(input logic [7:0] d, input logic lst);
    logic [7:0] factor;
    ecc_item_t  item;
    factor = d ^ rem_reg[0];
    for (int j = 0; j + 1 < eff_n; j++)
      rem_reg[j] = rem_reg[j+1] ^ gf256_product(factor, gen_coef[j]);
    rem_reg[eff_n-1] = gf256_product(factor, gen_coef[eff_n-1]);
    if (lst) begin
      for (int j = 0; j < eff_n; j++) begin
        item.ecc_byte = rem_reg[j];
        item.ecc_last = (j == eff_n - 1);
        pending_ecc.push_back(item);
      end
      for (int j = 0; j < MAXN; j++) rem_reg[j] = '0;
    end
  endfunction

  task automatic send_byte(input logic [7:0] d, input logic lst);
    in_valid     <= 1'b1;
    in_data_byte <= d;
    in_last_byte <= lst;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    absorb_byte(d, lst);
    // each following cycle is idle with the given chance
    while ($urandom_range(0, 99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic wait_results();
    in_valid <= 1'b0;
    while (pending_ecc.size() != 0) @(posedge clk);
  endtask

  // block fully idle: results drained and any stray absorb finished
  task automatic wait_drained();
    wait_results();
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_ecc_length(input logic [5:0] len);
    cfg_wr_data <= len;
    cfg_wr_en   <= 1'b1;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    rebuild_generator(len);
  endtask

  task automatic test_default_length();
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h01, 1'b1);
    send_byte(8'hFF, 1'b1);
  endtask

  task automatic test_length_extremes();
    wait_drained();
    write_ecc_length(6'd1);
    send_byte(8'hA5, 1'b0);
    send_byte(8'h5A, 1'b1);
    wait_drained();
    write_ecc_length(6'd32);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b1);
    wait_drained();
    write_ecc_length(6'd0);     // zero behaves as one
    send_byte(8'h3C, 1'b1);
    wait_drained();
    write_ecc_length(6'd63);    // clamps to the maximum
    send_byte(8'hC3, 1'b1);
  endtask

  // a length write part-way through a message throws that message away
  task automatic test_mid_message_write();
    wait_drained();
    write_ecc_length(6'd5);
    send_byte(8'h7E, 1'b0);
    send_byte(8'h81, 1'b0);
    send_byte(8'h42, 1'b0);
    wait_drained();
    write_ecc_length(6'd33);
    send_byte(8'h12, 1'b0);
    send_byte(8'h34, 1'b1);
  endtask

  task automatic test_pause_until_drained();
    send_byte(8'h55, 1'b0);
    send_byte(8'hAA, 1'b1);
    wait_results();
    send_byte(8'h0F, 1'b0);
    send_byte(8'hF0, 1'b1);
  endtask

  task automatic test_random_traffic(input int gap_pct, input int stall_pct,
                                     input logic [5:0] len, input int n_items);
    int sent;
    int msg_len;
    wait_drained();
    send_gap_pct  = gap_pct;
    out_stall_pct = stall_pct;
    write_ecc_length(len);
    sent = 0;
    while (sent < n_items) begin
      msg_len = $urandom_range(1, 8);
      if (msg_len > n_items - sent) msg_len = n_items - sent;
      for (int k = 0; k < msg_len; k++)
        send_byte(8'($urandom_range(0, 255)), k == msg_len - 1);
      sent += msg_len;
      if ($urandom_range(0, 9) == 0) wait_results();
    end
  endtask

  initial begin
    rebuild_generator(ECC_LEN_RESET);
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_default_length();
    test_length_extremes();
    test_mid_message_write();
    test_pause_until_drained();
    test_random_traffic(0, 0, 6'd32, 22);
    test_random_traffic(59, 0, 6'd1, 22);
    test_random_traffic(0, 59, 6'd17, 22);
    test_random_traffic(22, 22, 6'($urandom_range(1, 32)), 22);
    wait_drained();
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < out_stall_pct);
  end

  always @(posedge clk) begin : check_results
    ecc_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_ecc.size() == 0) begin
        $display("%0t: unexpected transaction: expected none, actual ecc_byte %02h ecc_last %0b",
                 $time, out_ecc_byte, out_ecc_last);
        mismatch_count++;
      end else begin
        want = pending_ecc.pop_front();
        if (out_ecc_byte !== want.ecc_byte) begin
          $display("%0t: ecc_byte mismatch: expected %02h actual %02h",
                   $time, want.ecc_byte, out_ecc_byte);
          mismatch_count++;
        end
        if (out_ecc_last !== want.ecc_last) begin
          $display("%0t: ecc_last mismatch: expected %0b actual %0b",
                   $time, want.ecc_last, out_ecc_last);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, pending_ecc.size());
      $display("simulation failed");
      $finish;
    end
  end

endmodule
